@@ sv/nrgd_pkg.sv @@
package nrgd_pkg;

  // Configuration register indexes.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BUDGET = 2'd1;

  // Encoding modes.
  localparam logic MODE_RAW = 1'b0;
  localparam logic MODE_RLE = 1'b1;

  // Run-length parser phases.
  localparam logic [1:0] PH_LIT   = 2'd0;
  localparam logic [1:0] PH_COUNT = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;

  localparam int CountW  = 16;
  localparam int CfgDataW = 16;
  localparam logic [3:0] LevelScale = 4'd1;

  // Result of evaluating one nibble against the glyph state.
  typedef struct packed {
    logic [3:0]        npix;
    logic [1:0]        phase;
    logic [3:0]        run;
    logic [CountW-1:0] emitted;
    logic              done;
  } nib_eval_t;

  // Pixel plan for one byte, handed from the sequencer to the emitter.
  typedef struct packed {
    logic [3:0] cnt_hi;
    logic [3:0] val_hi;
    logic [3:0] cnt_lo;
    logic [3:0] val_lo;
    logic       done;
  } byte_plan_t;

  // Grey level of a 4-bit index: index times 17, i.e. the nibble repeated.
  function automatic logic [7:0] nib_level(input logic [3:0] idx);
    nib_level = {idx, idx} & {8{LevelScale[0]}};
  endfunction

endpackage

@@ sv/nrgd_in_if.sv @@
interface nrgd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

@@ sv/nrgd_out_if.sv @@
interface nrgd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_level;
  logic       pixel_valid;
  logic       last;
  logic       glyph_done;

  modport source (output valid, output pixel_level, output pixel_valid, output last,
                  output glyph_done, input ready);
  modport sink (input valid, input pixel_level, input pixel_valid, input last,
                input glyph_done, output ready);
endinterface

@@ sv/nibble_rle_glyph_decoder.sv @@
// Channel    Dir  Payload                                     Word
// code_in    in   code_byte[7:0]                              one glyph byte
// pixel_out  out  pixel_level[7:0] pixel_valid last glyph_done one pixel or empty marker
// cfg        in   cfg_we cfg_index[1:0] cfg_data[15:0]        register write
//
// A byte is accepted, then passes through the shared nibble evaluator
// (high nibble, then low; only the high one when it ends the glyph), then the
// emitter gives one pixel word per pixel, at least one word.
// A new byte is accepted only once the emitter has issued the last one's words.
// Synchronous reset clears the sequencer, parser state, emitter and registers.
// A stalled pixel_out holds the emitter; code_in stays low-ready until it drains.
module nibble_rle_glyph_decoder
  import nrgd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  nrgd_in_if.sink             code_in,
  nrgd_out_if.source          pixel_out
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HI   = 2'd1;
  localparam logic [1:0] ST_LO   = 2'd2;

  logic [1:0]        state;
  logic              mode;
  logic [CountW-1:0] budget;
  logic [1:0]        phase;
  logic [3:0]        run;
  logic [CountW-1:0] emitted;
  logic [7:0]        code;
  logic [3:0]        cnt_hi;
  logic [3:0]        cur_nib;
  nib_eval_t         ev;
  byte_plan_t        plan;
  logic              start;
  logic              busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_RLE;
      budget <= CountW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode   <= cfg_data[0];
        REG_BUDGET: budget <= cfg_data[CountW-1:0];
        default:    ;
      endcase
    end
  end

  assign code_in.ready = (state == ST_IDLE) && !busy;
  assign cur_nib       = (state == ST_HI) ? code[7:4] : code[3:0];

  nrgd_nib_eval u_eval (
    .mode    (mode),
    .budget  (budget),
    .phase   (phase),
    .run     (run),
    .emitted (emitted),
    .nib     (cur_nib),
    .res     (ev)
  );

  // Plan handed to the emitter at the end of evaluation.
  always_comb begin
    start       = 1'b0;
    plan.cnt_hi = cnt_hi;
    plan.val_hi = code[7:4];
    plan.cnt_lo = 4'd0;
    plan.val_lo = code[3:0];
    plan.done   = ev.done;
    if (state == ST_HI) begin
      plan.cnt_hi = ev.npix;
      start       = ev.done;
    end else if (state == ST_LO) begin
      plan.cnt_lo = ev.npix;
      start       = 1'b1;
    end
  end

  // Sequencer and glyph state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      phase   <= PH_LIT;
      run     <= 4'd0;
      emitted <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (code_in.valid && code_in.ready) begin
            state <= ST_HI;
          end
        end
        ST_HI, ST_LO: begin
          if (ev.done) begin
            phase   <= PH_LIT;
            run     <= 4'd0;
            emitted <= '0;
          end else begin
            phase   <= ev.phase;
            run     <= ev.run;
            emitted <= ev.emitted;
          end
          state <= (state == ST_HI && !ev.done) ? ST_LO : ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Byte and high-nibble pixel count held across evaluation.
  always_ff @(posedge clk) begin
    if (code_in.valid && code_in.ready) begin
      code <= code_in.code_byte;
    end
    if (state == ST_HI) begin
      cnt_hi <= ev.npix;
    end
  end

  nrgd_emit u_emit (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .plan  (plan),
    .busy  (busy),
    .out   (pixel_out)
  );

endmodule

@@ sv/nrgd_nib_eval.sv @@
module nrgd_nib_eval
  import nrgd_pkg::*;
(
  input  logic              mode,
  input  logic [CountW-1:0] budget,
  input  logic [1:0]        phase,
  input  logic [3:0]        run,
  input  logic [CountW-1:0] emitted,
  input  logic [3:0]        nib,
  output nib_eval_t         res
);

  logic [CountW-1:0] room;
  logic [3:0]        want;
  logic              room_small;

  // Pixels still allowed in this glyph.
  always_comb begin
    room = '0;
    if (emitted < budget) begin
      room = budget - emitted;
    end
    room_small = (room < CountW'(want));
  end

  // Parse the nibble and clip its pixel count to the remaining room.
  always_comb begin
    want      = 4'd0;
    res.phase = phase;
    res.run   = run;
    res.done  = 1'b0;
    if (mode == MODE_RAW) begin
      want     = 4'd1;
      res.done = (room <= CountW'(1));
    end else begin
      case (phase)
        PH_COUNT: begin
          if (nib == 4'd0) begin
            res.done = 1'b1;
          end else begin
            res.run   = nib;
            res.phase = PH_VALUE;
          end
        end
        PH_VALUE: begin
          want      = run;
          res.run   = 4'd0;
          res.phase = PH_LIT;
        end
        default: begin
          if (nib != 4'd0) begin
            want      = 4'd1;
            res.phase = PH_LIT;
          end else begin
            res.phase = PH_COUNT;
          end
        end
      endcase
    end
    res.npix    = room_small ? room[3:0] : want;
    res.emitted = emitted + CountW'(res.npix);
  end

endmodule

@@ sv/nrgd_emit.sv @@
module nrgd_emit
  import nrgd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  byte_plan_t  plan,
  output logic        busy,
  nrgd_out_if.source  out
);

  logic       ovalid;
  logic [7:0] olevel;
  logic       opix;
  logic       olast;
  logic       odone;
  logic [3:0] cnt_hi;
  logic [3:0] val_hi;
  logic [3:0] cnt_lo;
  logic [3:0] val_lo;
  logic       done;
  logic       slot_free;
  logic       fire;
  logic       use_hi;
  logic       use_lo;
  logic       is_last;

  assign slot_free = !ovalid || out.ready;
  assign fire      = busy && slot_free;
  assign use_hi    = (cnt_hi != 4'd0);
  assign use_lo    = !use_hi && (cnt_lo != 4'd0);
  assign is_last   = use_hi ? (cnt_hi == 4'd1 && cnt_lo == 4'd0)
                   : use_lo ? (cnt_lo == 4'd1) : 1'b1;

  // Control: busy flag and output word valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (fire && is_last) begin
        busy <= 1'b0;
      end
      if (fire) begin
        ovalid <= 1'b1;
      end else if (out.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Plan counters: one pixel leaves per word, high nibble's run first.
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_hi <= plan.cnt_hi;
      val_hi <= plan.val_hi;
      cnt_lo <= plan.cnt_lo;
      val_lo <= plan.val_lo;
      done   <= plan.done;
    end else if (fire) begin
      if (use_hi) begin
        cnt_hi <= cnt_hi - 4'd1;
      end else if (use_lo) begin
        cnt_lo <= cnt_lo - 4'd1;
      end
    end
  end

  // Output word register; a byte with no pixel gives one empty word.
  always_ff @(posedge clk) begin
    if (fire) begin
      olevel <= use_hi ? nib_level(val_hi) : use_lo ? nib_level(val_lo) : 8'd0;
      opix   <= use_hi || use_lo;
      olast  <= is_last;
      odone  <= is_last && done;
    end
  end

  assign out.valid       = ovalid;
  assign out.pixel_level = olevel;
  assign out.pixel_valid = opix;
  assign out.last        = olast;
  assign out.glyph_done  = odone;

endmodule
